// File: src/assert_macros.svh
// Assertion macros used by the port-level checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Plain property check, disabled while reset is asserted.
`define CHG_ASSERT(lbl, clk, rstn, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (prop)) \
    else $error("assertion failed");

// Implication check: antecedent on one side, consequence on the next edge.
`define CHG_ASSERT_NEXT(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
    else $error("assertion failed");

`endif

// File: src/chg_pkg.sv
// Types and constants for the coordinate hash pipeline.
package chg_pkg;

  localparam int unsigned HASH_BYTES = 8;
  localparam int unsigned DIV5_SHIFT = 34;

  localparam logic [31:0] ELIGIBLE_MASK = 32'h0001_1111;
  // ceil(2^34 / 5): exact quotient by five for any 32-bit dividend
  localparam logic [31:0] RECIP5 = 32'hCCCC_CCCD;

  // Hash state handed from cell to cell: running hash and the bytes still to mix.
  typedef struct packed {
    logic [31:0] h;
    logic [63:0] bytes;
  } mix_t;

  // One result beat.
  typedef struct packed {
    logic [31:0] hash_value;
    logic        is_eligible;
    logic [1:0]  glitter_phase;
  } res_t;

endpackage

// File: src/chg_intf.sv
// Channel interfaces: coordinate input, hash result output, frame register write.
interface chg_in_if #(
  parameter int unsigned COORD_BITS = 16
);
  logic                  valid;
  logic                  ready;
  logic [COORD_BITS-1:0] coord_x;
  logic [COORD_BITS-1:0] coord_y;

  modport source (output valid, output coord_x, output coord_y, input ready);
  modport sink (input valid, input coord_x, input coord_y, output ready);
endinterface

interface chg_out_if;
  logic        valid;
  logic        ready;
  logic [31:0] hash_value;
  logic        is_eligible;
  logic [1:0]  glitter_phase;

  modport source (output valid, output hash_value, output is_eligible,
                  output glitter_phase, input ready);
  modport sink (input valid, input hash_value, input is_eligible,
                input glitter_phase, output ready);
endinterface

interface chg_cfg_if;
  logic        valid;
  logic        ready;
  logic [31:0] frame_number;

  modport source (output valid, output frame_number, input ready);
  modport sink (input valid, input frame_number, output ready);
endinterface

// File: src/chg_mix_cell.sv
// One cell of the hash chain: mixes the lowest pending byte into the running hash.
module chg_mix_cell (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          in_valid_i,
  input  chg_pkg::mix_t in_data_i,
  output logic          in_ready_o,
  output logic          out_valid_o,
  output chg_pkg::mix_t out_data_o,
  input  logic          out_ready_i
);
  import chg_pkg::*;

  logic        valid_q;
  mix_t        data_q;
  mix_t        data_d;
  logic [31:0] h_add;
  logic [31:0] h_sh;

  assign in_ready_o = !valid_q || out_ready_i;

  always_comb begin
    h_add        = in_data_i.h + {24'd0, in_data_i.bytes[7:0]};
    h_sh         = h_add + (h_add << 10);
    data_d.h     = h_sh ^ (h_sh >> 6);
    data_d.bytes = in_data_i.bytes >> 8;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (in_ready_o) begin
      valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_ready_o && in_valid_i) begin
      data_q <= data_d;
    end
  end

  assign out_valid_o = valid_q;
  assign out_data_o  = data_q;

endmodule

// File: src/chg_tail.sv
// Final avalanche, eligibility test and glitter phase, four registered stages.
module chg_tail (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          in_valid_i,
  input  logic [31:0]   hash_i,
  input  logic [31:0]   frame_i,
  output logic          in_ready_o,
  output logic          out_valid_o,
  output chg_pkg::res_t out_res_o,
  input  logic          out_ready_i
);
  import chg_pkg::*;

  logic [3:0]  valid_q;
  logic [4:0]  rdy;
  logic [31:0] h0_q, h1_q, h2_q, sum_q;
  logic        elig_q;
  res_t        res_q;
  logic [31:0] t0, h0_d, h1_d, sum_d;
  logic [63:0] prod;

  always_comb begin
    rdy[4] = out_ready_i;
    rdy[3] = !valid_q[3] || rdy[4];
    rdy[2] = !valid_q[2] || rdy[3];
    rdy[1] = !valid_q[1] || rdy[2];
    rdy[0] = !valid_q[0] || rdy[1];
  end

  assign in_ready_o = rdy[0];

  always_comb begin
    t0    = hash_i + (hash_i << 3);
    h0_d  = t0 ^ (t0 >> 11);
    h1_d  = h0_q + (h0_q << 15);
    sum_d = (h1_q >> 4) + frame_i;
    prod  = {32'd0, sum_q} * {32'd0, RECIP5};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= '0;
    end else begin
      if (rdy[0]) valid_q[0] <= in_valid_i;
      if (rdy[1]) valid_q[1] <= valid_q[0];
      if (rdy[2]) valid_q[2] <= valid_q[1];
      if (rdy[3]) valid_q[3] <= valid_q[2];
    end
  end

  always_ff @(posedge clk_i) begin
    if (rdy[0] && in_valid_i) begin
      h0_q <= h0_d;
    end
    if (rdy[1] && valid_q[0]) begin
      h1_q <= h1_d;
    end
    if (rdy[2] && valid_q[1]) begin
      h2_q   <= h1_q;
      sum_q  <= sum_d;
      elig_q <= (h1_q & ELIGIBLE_MASK) == 32'd0;
    end
    if (rdy[3] && valid_q[2]) begin
      res_q.hash_value    <= h2_q;
      res_q.is_eligible   <= elig_q;
      // quotient by five is prod >> 34; only its two low bits are kept
      res_q.glitter_phase <= prod[DIV5_SHIFT+1:DIV5_SHIFT];
    end
  end

  assign out_valid_o = valid_q[3];
  assign out_res_o   = res_q;

endmodule

// File: src/coordinate_hash_glitter.sv
// Coordinate hash: eight mix cells in a row, then a four-stage finishing tail.
// An accepted input beat passes each cell register and then each tail stage on its way to out_ch.
// Throughput: one coordinate per cycle while out_ch is ready; each cell and tail stage holds one beat.
// Backpressure stalls only the stages that are full, so bubbles get squeezed out.
// Reset clears all valid bits and sets frame_number to 0; payload is not reset.
module coordinate_hash_glitter #(
  parameter int unsigned COORD_BITS = 16
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  chg_in_if.sink    in_ch,
  chg_out_if.source out_ch,
  chg_cfg_if.sink   cfg_ch
);
  import chg_pkg::*;

  logic                  stg_valid [HASH_BYTES+1];
  logic                  stg_ready [HASH_BYTES+1];
  mix_t                  stg_data  [HASH_BYTES+1];
  logic [31:0]           frame_q;
  res_t                  res;
  logic [COORD_BITS-1:0] coord_x;
  logic [COORD_BITS-1:0] coord_y;

  assign cfg_ch.ready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      frame_q <= '0;
    end else if (cfg_ch.valid) begin
      frame_q <= cfg_ch.frame_number;
    end
  end

  assign coord_x = in_ch.coord_x;
  assign coord_y = in_ch.coord_y;

  // x then y as little-endian words: x occupies the low four bytes
  assign stg_valid[0] = in_ch.valid;
  assign in_ch.ready  = stg_ready[0];
  assign stg_data[0]  = {32'd0, 32'(coord_y), 32'(coord_x)};

  for (genvar i = 0; i < HASH_BYTES; i++) begin : g_cell
    chg_mix_cell u_cell (
      .clk_i       (clk_i),
      .rst_ni      (rst_ni),
      .in_valid_i  (stg_valid[i]),
      .in_data_i   (stg_data[i]),
      .in_ready_o  (stg_ready[i]),
      .out_valid_o (stg_valid[i+1]),
      .out_data_o  (stg_data[i+1]),
      .out_ready_i (stg_ready[i+1])
    );
  end

  chg_tail u_tail (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (stg_valid[HASH_BYTES]),
    .hash_i      (stg_data[HASH_BYTES].h),
    .frame_i     (frame_q),
    .in_ready_o  (stg_ready[HASH_BYTES]),
    .out_valid_o (out_ch.valid),
    .out_res_o   (res),
    .out_ready_i (out_ch.ready)
  );

  assign out_ch.hash_value    = res.hash_value;
  assign out_ch.is_eligible   = res.is_eligible;
  assign out_ch.glitter_phase = res.glitter_phase;

endmodule

// File: src/chg_checker.sv
// Port-level checker for the coordinate hash block, bound to the top level.
`include "assert_macros.svh"

module chg_port_checker (
  input logic       clk_i,
  input logic       rst_ni,
  chg_in_if.sink    in_ch,
  chg_out_if.source out_ch,
  chg_cfg_if.sink   cfg_ch
);
  import chg_pkg::*;

  logic        out_stall;
  logic        elig_ok;
  logic [34:0] out_beat;

  assign out_stall = out_ch.valid && !out_ch.ready;
  assign elig_ok   = out_ch.is_eligible == ((out_ch.hash_value & ELIGIBLE_MASK) == 32'd0);
  assign out_beat  = {out_ch.hash_value, out_ch.is_eligible, out_ch.glitter_phase};

  `CHG_ASSERT_NEXT(a_out_valid_hold, clk_i, rst_ni, out_stall, out_ch.valid)
  `CHG_ASSERT_NEXT(a_out_data_hold, clk_i, rst_ni, out_stall, $stable(out_beat))
  `CHG_ASSERT(a_elig_match, clk_i, rst_ni, !out_ch.valid || elig_ok)
  `CHG_ASSERT(a_no_bubble_stall, clk_i, rst_ni, !out_ch.ready || in_ch.ready)
  `CHG_ASSERT(a_cfg_ready, clk_i, rst_ni, cfg_ch.ready)

endmodule

bind coordinate_hash_glitter chg_port_checker u_chg_checker (
  .clk_i  (clk_i),
  .rst_ni (rst_ni),
  .in_ch  (in_ch),
  .out_ch (out_ch),
  .cfg_ch (cfg_ch)
);

// File: bench/chg_checker.sv
// Checker for the coordinate hash block: predicts each result beat and compares it.
`timescale 1ns / 1ps

module chg_checker #(
  parameter int unsigned COORD_BITS = 16
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  in_valid_i,
  input  logic                  in_ready_i,
  input  logic [COORD_BITS-1:0] coord_x_i,
  input  logic [COORD_BITS-1:0] coord_y_i,
  input  logic                  out_valid_i,
  input  logic                  out_ready_i,
  input  logic [31:0]           hash_value_i,
  input  logic                  is_eligible_i,
  input  logic [1:0]            glitter_phase_i,
  input  logic                  cfg_valid_i,
  input  logic                  cfg_ready_i,
  input  logic [31:0]           cfg_frame_i,
  output int unsigned           fail_count_o,
  output int unsigned           pending_o
);
  import chg_pkg::*;

  localparam int unsigned MAX_REPORTS = 10;

  typedef struct {
    logic [COORD_BITS-1:0] x;
    logic [COORD_BITS-1:0] y;
    res_t                  star;
  } star_expect_t;

  star_expect_t pending_stars[$];
  logic [31:0]  frame_q = '0;
  int unsigned  mismatches = 0;

  initial begin
    fail_count_o = 0;
    pending_o    = 0;
  end

  // One round of the one-at-a-time mix for a single byte.
  function automatic logic [31:0] oaat_round(logic [31:0] h, logic [7:0] b);
    logic [31:0] t;
    t = h + {24'd0, b};
    t = t + (t << 10);
    t = t ^ (t >> 6);
    return t;
  endfunction

  function automatic res_t predict_star(logic [COORD_BITS-1:0] x, logic [COORD_BITS-1:0] y,
                                        logic [31:0] frame);
    logic [63:0] msg;
    logic [31:0] h;
    logic [31:0] sum;
    res_t        r;
    // x in the low word, bytes fed low to high
    msg = {32'(y), 32'(x)};
    h = '0;
    for (int k = 0; k < 8; k++) h = oaat_round(h, msg[8*k +: 8]);
    h = h + (h << 3);
    h = h ^ (h >> 11);
    h = h + (h << 15);
    sum = (h >> 4) + frame;  // wraps mod 2^32
    r.hash_value    = h;
    r.is_eligible   = ((h & ELIGIBLE_MASK) == '0);
    r.glitter_phase = 2'(sum / 32'd5);
    return r;
  endfunction

  always @(posedge clk_i) begin
    star_expect_t exp_beat;
    if (!rst_ni) begin
      frame_q = '0;
    end else begin
      if (cfg_valid_i && cfg_ready_i) frame_q = cfg_frame_i;
      if (in_valid_i && in_ready_i) begin
        exp_beat.x    = coord_x_i;
        exp_beat.y    = coord_y_i;
        exp_beat.star = predict_star(coord_x_i, coord_y_i, frame_q);
        pending_stars.push_back(exp_beat);
      end
      if (out_valid_i && out_ready_i) begin
        if (pending_stars.size() == 0) begin
          if (mismatches < MAX_REPORTS)
            $display("%0t: result beat with none expected: hash %h elig %b phase %0d",
                     $time, hash_value_i, is_eligible_i, glitter_phase_i);
          mismatches++;
        end else begin
          exp_beat = pending_stars.pop_front();
          if (hash_value_i !== exp_beat.star.hash_value ||
              is_eligible_i !== exp_beat.star.is_eligible ||
              glitter_phase_i !== exp_beat.star.glitter_phase) begin
            if (mismatches < MAX_REPORTS)
              $display("%0t: (%h,%h) frame %h exp %h/%b/%0d got %h/%b/%0d",
                       $time, exp_beat.x, exp_beat.y, frame_q,
                       exp_beat.star.hash_value, exp_beat.star.is_eligible,
                       exp_beat.star.glitter_phase,
                       hash_value_i, is_eligible_i, glitter_phase_i);
            mismatches++;
          end
        end
      end
    end
    fail_count_o <= mismatches;
    pending_o    <= pending_stars.size();
  end

endmodule

// File: bench/testbench.sv
// Top of the coordinate hash bench: clock, reset, beat traffic and verdict.
`timescale 1ns / 1ps

module testbench;
  localparam int unsigned COORD_BITS       = 16;
  localparam int unsigned PIPE_LATENCY     = 12;
  localparam int unsigned RANDOM_PER_PHASE = 480;

  localparam logic [15:0] CORNER_X [12] = '{16'h0000, 16'hFFFF, 16'h0000, 16'hFFFF,
                                            16'h0001, 16'h0000, 16'h8000, 16'h7FFF,
                                            16'h00FF, 16'hFF00, 16'hAAAA, 16'h5555};
  localparam logic [15:0] CORNER_Y [12] = '{16'h0000, 16'hFFFF, 16'hFFFF, 16'h0000,
                                            16'h0000, 16'h0001, 16'h8000, 16'h7FFF,
                                            16'hFF00, 16'h00FF, 16'h5555, 16'hAAAA};

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  int unsigned sender_idle_pct = 0;
  int unsigned receiver_stall_pct = 0;
  int unsigned fail_count;
  int unsigned pending;

  chg_in_if #(.COORD_BITS(COORD_BITS)) in_ch();
  chg_out_if                           out_ch();
  chg_cfg_if                           cfg_ch();

  coordinate_hash_glitter #(.COORD_BITS(COORD_BITS)) dut (
    .clk_i  (clk),
    .rst_ni (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch),
    .cfg_ch (cfg_ch)
  );

  chg_checker #(.COORD_BITS(COORD_BITS)) checker_i (
    .clk_i           (clk),
    .rst_ni          (rst_n),
    .in_valid_i      (in_ch.valid),
    .in_ready_i      (in_ch.ready),
    .coord_x_i       (in_ch.coord_x),
    .coord_y_i       (in_ch.coord_y),
    .out_valid_i     (out_ch.valid),
    .out_ready_i     (out_ch.ready),
    .hash_value_i    (out_ch.hash_value),
    .is_eligible_i   (out_ch.is_eligible),
    .glitter_phase_i (out_ch.glitter_phase),
    .cfg_valid_i     (cfg_ch.valid),
    .cfg_ready_i     (cfg_ch.ready),
    .cfg_frame_i     (cfg_ch.frame_number),
    .fail_count_o    (fail_count),
    .pending_o       (pending)
  );

  always #10 clk = ~clk;

  always @(posedge clk) begin
    out_ch.ready <= ($urandom_range(99) >= receiver_stall_pct);
  end

  function automatic logic [15:0] pick_coord();
    case ($urandom_range(7))
      0: return 16'h0000;
      1: return 16'hFFFF;
      2: return 16'($urandom_range(255));
      3: return 16'hFFFF ^ 16'($urandom_range(255));
      default: return 16'($urandom);
    endcase
  endfunction

  task automatic send_coord(logic [15:0] x, logic [15:0] y);
    int unsigned gap;
    gap = 0;
    while (gap < 40 && $urandom_range(99) < sender_idle_pct) gap++;
    if (gap != 0) begin
      in_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_ch.valid   <= 1'b1;
    in_ch.coord_x <= x;
    in_ch.coord_y <= y;
    do @(posedge clk); while (!in_ch.ready);
  endtask

  task automatic write_frame(logic [31:0] frame);
    cfg_ch.valid        <= 1'b1;
    cfg_ch.frame_number <= frame;
    do @(posedge clk); while (!cfg_ch.ready);
    cfg_ch.valid <= 1'b0;
  endtask

  // First edge lets the checker count the last accepted beat.
  task automatic drain_results();
    in_ch.valid <= 1'b0;
    do @(posedge clk); while (pending != 0);
  endtask

  task automatic run_phase(logic [31:0] frame, int unsigned idle, int unsigned stall,
                           int unsigned count);
    drain_results();
    write_frame(frame);
    sender_idle_pct = idle;
    receiver_stall_pct <= stall;
    repeat (count) send_coord(pick_coord(), pick_coord());
  endtask

  initial begin
    in_ch.valid         = 1'b0;
    in_ch.coord_x       = '0;
    in_ch.coord_y       = '0;
    out_ch.ready        = 1'b0;
    cfg_ch.valid        = 1'b0;
    cfg_ch.frame_number = '0;
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // corners and walking bits, frame at zero
    write_frame(32'h0000_0000);
    for (int i = 0; i < 12; i++) send_coord(CORNER_X[i], CORNER_Y[i]);
    for (int k = 0; k < 8; k++) send_coord(16'(1) << (2 * k), 16'(1) << (2 * k + 1));

    run_phase(32'hFFFF_FFFF, 0, 0, RANDOM_PER_PHASE);
    run_phase($urandom, 80, 0, RANDOM_PER_PHASE);
    run_phase(32'hFFFF_FFFB, 0, 80, RANDOM_PER_PHASE);
    run_phase(32'h8000_0001, 10, 10, RANDOM_PER_PHASE);

    drain_results();
    receiver_stall_pct <= 0;
    repeat (PIPE_LATENCY + 4) @(posedge clk);
    if (fail_count == 0 && pending == 0) begin
      $display("PASS coordinate_hash_glitter");
    end else begin
      $display("FAIL coordinate_hash_glitter");
    end
    $finish;
  end

  initial begin
    #5_000_000;
    $display("FAIL coordinate_hash_glitter");
    $finish;
  end

endmodule

// File: files.f
+incdir+src
src/chg_pkg.sv
src/chg_intf.sv
src/chg_mix_cell.sv
src/chg_tail.sv
src/coordinate_hash_glitter.sv
src/chg_checker.sv
bench/chg_checker.sv
bench/testbench.sv
